// ===== rtl/core/u8n1_pkg.sv =====
// ----------------------------------------------------------------------------
// u8n1_pkg
// Shared widths, constants and status types of the 8N1 serial transceiver.
// ----------------------------------------------------------------------------
package u8n1_pkg;

  localparam int TICK_W   = 16;   // bit period register and tx tick counter
  localparam int RX_CNT_W = 17;   // rx countdown, holds 1.5 bit periods
  localparam int DATA_W   = 8;
  localparam int TX_POS_W = 4;    // 0 start, 1..8 data, 9 stop
  localparam int RX_POS_W = 3;
  localparam int IN_W     = 16;   // packed input item, padded to bytes
  localparam int OUT_W    = 16;   // packed result item, padded to bytes

  localparam logic [TICK_W-1:0]   BIT_TICKS_RESET = 16'd104;
  localparam logic [TX_POS_W-1:0] TX_POS_START    = 4'd0;
  localparam logic [TX_POS_W-1:0] TX_POS_LAST_DATA = 4'd8;
  localparam logic [TX_POS_W-1:0] TX_POS_END      = 4'd10;
  localparam logic [RX_POS_W-1:0] RX_POS_LAST     = 3'd7;

  // transmitter status for the current tick
  typedef struct packed {
    logic line;
    logic busy;
  } tx_status_t;

  // receiver result for the current tick
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] data;
  } rx_result_t;

endpackage

// ===== rtl/core/uart_8n1_transceiver_top.sv =====
// ----------------------------------------------------------------------------
// uart_8n1_transceiver_top
// 8N1 serial transmitter and receiver stepped once per accepted input item.
// ----------------------------------------------------------------------------
// Each transfer on the s_ side is one timebase tick: the sampled rx line
// level plus an optional transmit request with its byte. Each tick yields
// exactly one result transfer on the m_ side with the tx line level, the
// busy flag, and a one-tick rx_valid pulse with the received byte.
// cfg_we/cfg_wdata load the bit period in ticks (reset value 104); write it
// only while the stream is idle. A period of zero acts as one.
// The result is in the output register the cycle after the input transfer.
// Throughput: one item per cycle unless m_ stalls, set by the single output
// register; transmitter and receiver state update in the accepting cycle.
// s_tready is high whenever the output register is empty or being drained,
// so a stalled m_ side holds one result and then back-pressures s_.
// Reset (rst, synchronous) returns both sides to idle, clears the output
// valid flag and restores the bit period to 104.
// ----------------------------------------------------------------------------
module uart_8n1_transceiver_top
  import u8n1_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              cfg_we,
  input  logic [TICK_W-1:0] cfg_wdata,
  // input ticks
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // [0] rx_level, [1] tx_start, [9:2] tx_byte
  // results
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata    // [0] tx_line, [1] tx_busy, [2] rx_valid,
                                       // [10:3] rx_byte
);

  logic [TICK_W-1:0] bit_ticks;
  logic [TICK_W-1:0] period;
  logic              step;
  tx_status_t        tx_stat;
  rx_result_t        rx_res;

  // bit period register
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_ticks <= BIT_TICKS_RESET;
    end else if (cfg_we) begin
      bit_ticks <= cfg_wdata;
    end
  end

  assign period   = (bit_ticks == '0) ? TICK_W'(1) : bit_ticks;
  assign s_tready = !m_tvalid || m_tready;
  assign step     = s_tvalid && s_tready;

  u8n1_tx u_tx (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .start  (s_tdata[1]),
    .data   (s_tdata[9:2]),
    .period (period),
    .status (tx_stat)
  );

  u8n1_rx u_rx (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .level  (s_tdata[0]),
    .period (period),
    .result (rx_res)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= {5'b0, rx_res.data, rx_res.valid, tx_stat.busy, tx_stat.line};
    end
  end

endmodule

// ===== rtl/core/u8n1_tx.sv =====
// ----------------------------------------------------------------------------
// u8n1_tx
// 8N1 transmitter: start bit, 8 data bits LSB first, stop bit, one tick/step.
// ----------------------------------------------------------------------------
module u8n1_tx
  import u8n1_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              start,
  input  logic [DATA_W-1:0] data,
  input  logic [TICK_W-1:0] period,
  output tx_status_t        status
);

  logic                active;
  logic [TX_POS_W-1:0] pos;
  logic [TICK_W-1:0]   cnt;
  logic [DATA_W-1:0]   shreg;

  logic                active_next;
  logic [TX_POS_W-1:0] pos_next;
  logic [TICK_W-1:0]   cnt_next;
  logic [DATA_W-1:0]   shreg_next;

  logic                act_eff;
  logic [TX_POS_W-1:0] pos_eff;
  logic [TICK_W-1:0]   cnt_inc;
  logic [TX_POS_W-1:0] pos_inc;
  logic [RX_POS_W-1:0] bit_idx;

  // a request on an idle tick starts the frame on this very tick
  always_comb begin
    act_eff    = active | start;
    shreg_next = active ? shreg : data;
    pos_eff    = active ? pos : TX_POS_START;
    cnt_inc    = (active ? cnt : '0) + 1'b1;
    pos_inc    = pos_eff + 1'b1;
    bit_idx    = RX_POS_W'(pos_eff - 1'b1);

    status.busy = act_eff;
    status.line = 1'b1;
    active_next = act_eff;
    pos_next    = pos_eff;
    cnt_next    = cnt_inc;

    if (act_eff) begin
      if (pos_eff == TX_POS_START) begin
        status.line = 1'b0;
      end else if (pos_eff <= TX_POS_LAST_DATA) begin
        status.line = shreg_next[bit_idx];
      end
      // bit period elapsed (wrap to zero also ends it)
      if (cnt_inc >= period || cnt_inc == '0) begin
        cnt_next = '0;
        pos_next = pos_inc;
        if (pos_inc >= TX_POS_END) begin
          pos_next    = TX_POS_START;
          active_next = 1'b0;
        end
      end
    end else begin
      pos_next = pos;
      cnt_next = cnt;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      pos    <= '0;
      cnt    <= '0;
      shreg  <= '0;
    end else if (step) begin
      active <= active_next;
      pos    <= pos_next;
      cnt    <= cnt_next;
      shreg  <= shreg_next;
    end
  end

endmodule

// ===== rtl/core/u8n1_rx.sv =====
// ----------------------------------------------------------------------------
// u8n1_rx
// 8N1 receiver: start detect, mid-bit sampling, wait for idle, byte pulse.
// ----------------------------------------------------------------------------
module u8n1_rx
  import u8n1_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              level,
  input  logic [TICK_W-1:0] period,
  output rx_result_t        result
);

  typedef enum logic [3:0] {
    RX_IDLE   = 4'b0001,
    RX_SAMPLE = 4'b0010,
    RX_TRAIL  = 4'b0100,
    RX_WAIT   = 4'b1000
  } rx_phase_t;

  rx_phase_t             phase, phase_next;
  logic [RX_CNT_W-1:0]   cnt, cnt_next;
  logic [RX_POS_W-1:0]   pos, pos_next;
  logic [DATA_W-1:0]     shreg, shreg_next;
  logic [RX_CNT_W-1:0]   cnt_dec;

  // next state for one tick
  always_comb begin
    phase_next   = phase;
    cnt_next     = cnt;
    pos_next     = pos;
    shreg_next   = shreg;
    cnt_dec      = cnt - 1'b1;
    result.valid = 1'b0;
    result.data  = '0;

    unique case (phase)
      RX_IDLE: begin
        if (!level) begin
          phase_next = RX_SAMPLE;
          cnt_next   = {1'b0, period} + RX_CNT_W'(period >> 1);
          pos_next   = '0;
          shreg_next = '0;
        end
      end
      RX_SAMPLE: begin
        cnt_next = cnt_dec;
        if (cnt_dec == '0) begin
          shreg_next[pos] = shreg[pos] | level;
          cnt_next        = {1'b0, period};
          pos_next        = pos + 1'b1;
          if (pos == RX_POS_LAST) begin
            phase_next = RX_TRAIL;
          end
        end
      end
      RX_TRAIL: begin
        cnt_next = cnt_dec;
        if (cnt_dec == '0) begin
          phase_next = RX_WAIT;
          if (level) begin
            phase_next   = RX_IDLE;
            result.valid = 1'b1;
            result.data  = shreg;
          end
        end
      end
      RX_WAIT: begin
        if (level) begin
          phase_next   = RX_IDLE;
          result.valid = 1'b1;
          result.data  = shreg;
        end
      end
      default: begin
        phase_next = RX_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= RX_IDLE;
      cnt   <= '0;
      pos   <= '0;
      shreg <= '0;
    end else if (step) begin
      phase <= phase_next;
      cnt   <= cnt_next;
      pos   <= pos_next;
      shreg <= shreg_next;
    end
  end

endmodule

// ===== test/uart_8n1_transceiver_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_8n1_transceiver_top_test
// Self-checking bench for the 8N1 serial transceiver.
// ----------------------------------------------------------------------------
// Each input transfer is one timebase tick: an rx line level and an optional
// transmit request. Serial frames are played onto the rx line, mostly clean
// with random bytes and some broken or glitchy ones, while transmit requests
// arrive at random. A tick-level predictor of both state machines computes
// the tx line, busy flag and rx byte for every tick, and each result transfer
// is checked against the oldest prediction. Both stream sides idle at random,
// and the bit period is rewritten between phases, extremes included.
// ----------------------------------------------------------------------------
module uart_8n1_transceiver_top_test;
  import u8n1_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int REPORT_MAX  = 10;
  localparam int HOLD_LEN    = 200;  // long result-side stall for the fill test

  typedef enum logic [1:0] {
    RX_IDLE,
    RX_DATA,
    RX_TRAIL,
    RX_WAIT_HIGH
  } rx_state_e;

  // one result transfer, same bit order as m_tdata[10:0]
  typedef struct packed {
    logic [DATA_W-1:0] rx_data;
    logic              rx_valid;
    logic              tx_busy;
    logic              tx_line;
  } tick_result_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic [TICK_W-1:0] cfg_wdata;
  logic              s_tvalid;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata;   // [0] rx_level, [1] tx_start, [9:2] tx_byte
  logic              m_tvalid;
  logic              m_tready;
  logic [OUT_W-1:0]  m_tdata;   // [0] tx_line, [1] tx_busy, [2] rx_valid,
                                // [10:3] rx_byte

  // predictor state
  logic [TICK_W-1:0]   period_cfg;
  logic                tx_on;
  logic [TX_POS_W-1:0] tx_slot;
  logic [TICK_W-1:0]   tx_count;
  logic [DATA_W-1:0]   tx_data;
  rx_state_e           rx_state;
  logic [RX_CNT_W-1:0] rx_count;
  logic [RX_POS_W-1:0] rx_slot;
  logic [DATA_W-1:0]   rx_data;

  tick_result_t expected_ticks[$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  int           hold_cycles = 0;
  bit           no_gaps = 1'b0;

  uart_8n1_transceiver_top u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("uart_8n1_transceiver_top_test: done, errors");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [TICK_W-1:0] eff_period();
    return (period_cfg == '0) ? TICK_W'(1) : period_cfg;
  endfunction

  function automatic logic [DATA_W-1:0] rand_byte();
    return DATA_W'($urandom_range(0, 255));
  endfunction

  task automatic reset_prediction();
    period_cfg = BIT_TICKS_RESET;
    tx_on      = 1'b0;
    tx_slot    = TX_POS_START;
    tx_count   = '0;
    tx_data    = '0;
    rx_state   = RX_IDLE;
    rx_count   = '0;
    rx_slot    = '0;
    rx_data    = '0;
  endtask

  // advance both state machines by one tick and queue the expected result
  task automatic predict_tick(input logic rx_lvl, input logic tx_req,
                              input logic [DATA_W-1:0] tx_in);
    tick_result_t        res;
    logic [TICK_W-1:0]   per;
    logic [RX_CNT_W-1:0] per_wide;
    per      = eff_period();
    per_wide = RX_CNT_W'(per);
    res         = '0;
    res.tx_line = 1'b1;

    // transmitter: a request is taken only while idle
    if (!tx_on && tx_req) begin
      tx_on    = 1'b1;
      tx_slot  = TX_POS_START;
      tx_count = '0;
      tx_data  = tx_in;
    end
    if (tx_on) begin
      res.tx_busy = 1'b1;
      if (tx_slot == TX_POS_START)
        res.tx_line = 1'b0;
      else if (tx_slot <= TX_POS_LAST_DATA)
        res.tx_line = tx_data[tx_slot - 4'd1];
      else
        res.tx_line = 1'b1;
      tx_count = tx_count + 1'b1;
      if (tx_count >= per || tx_count == '0) begin
        tx_count = '0;
        tx_slot  = tx_slot + 1'b1;
        if (tx_slot >= TX_POS_END) begin
          tx_slot = TX_POS_START;
          tx_on   = 1'b0;
        end
      end
    end

    // receiver
    case (rx_state)
      RX_IDLE: begin
        if (!rx_lvl) begin
          rx_state = RX_DATA;
          rx_count = per_wide + (per_wide >> 1);
          rx_slot  = '0;
          rx_data  = '0;
        end
      end
      RX_DATA: begin
        rx_count = rx_count - 1'b1;
        if (rx_count == '0) begin
          rx_data[rx_slot] = rx_lvl;
          rx_count = per_wide;
          if (rx_slot == RX_POS_LAST) begin
            rx_slot  = '0;
            rx_state = RX_TRAIL;
          end else begin
            rx_slot = rx_slot + 1'b1;
          end
        end
      end
      RX_TRAIL: begin
        rx_count = rx_count - 1'b1;
        if (rx_count == '0) begin
          if (rx_lvl) begin
            rx_state     = RX_IDLE;
            res.rx_valid = 1'b1;
            res.rx_data  = rx_data;
          end else begin
            rx_state = RX_WAIT_HIGH;
          end
        end
      end
      default: begin
        if (rx_lvl) begin
          rx_state     = RX_IDLE;
          res.rx_valid = 1'b1;
          res.rx_data  = rx_data;
        end
      end
    endcase
    expected_ticks.push_back(res);
  endtask

  // one tick transfer on the input side, with an optional gap before it
  task automatic send_tick(input logic rx_lvl, input logic tx_req,
                           input logic [DATA_W-1:0] tx_in);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_W-DATA_W-2){1'b0}}, tx_in, tx_req, rx_lvl};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_tick(rx_lvl, tx_req, tx_in);
  endtask

  // n ticks at a fixed rx level, transmit requests at random if enabled
  task automatic send_level(input logic lvl, input int n, input bit tx_noise);
    for (int i = 0; i < n; i++)
      send_tick(lvl, tx_noise && ($urandom_range(0, 7) == 0), rand_byte());
  endtask

  // one serial frame on the rx line; tx_at picks the tick of a fixed request
  task automatic send_frame(input logic [DATA_W-1:0] data, input int bit_len,
                            input logic stop_lvl, input int tx_at,
                            input logic [DATA_W-1:0] tx_pick, input bit tx_noise);
    logic [9:0]        levels;
    logic              req;
    logic [DATA_W-1:0] txb;
    int                k;
    levels = {stop_lvl, data, 1'b0};
    k = 0;
    for (int b = 0; b < 10; b++) begin
      for (int t = 0; t < bit_len; t++) begin
        if (k == tx_at) begin
          req = 1'b1;
          txb = tx_pick;
        end else begin
          req = tx_noise && ($urandom_range(0, 7) == 0);
          txb = rand_byte();
        end
        send_tick(levels[b], req, txb);
        k++;
      end
    end
  endtask

  // drop valid and wait until every predicted result has been checked
  task automatic quiesce();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
  endtask

  task automatic set_bit_ticks(input logic [TICK_W-1:0] value);
    quiesce();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    period_cfg = value;
  endtask

  // idle gaps, and frames on the rx line if rx_frames is set, until n ticks have gone out
  task automatic run_traffic(input int n_ticks, input bit rx_frames);
    int sent;
    int per;
    int kind;
    int len;
    int idle_cap;
    sent = 0;
    while (sent < n_ticks) begin
      per      = int'(eff_period());
      idle_cap = (2 * per < 16) ? 2 * per : 16;
      len      = $urandom_range(rx_frames ? 0 : 1, idle_cap);
      send_level(1'b1, len, 1'b1);
      sent += len;
      if (rx_frames) begin
        kind = $urandom_range(0, 9);
        if (kind == 9) begin
          // short low glitch while idle
          len = $urandom_range(1, per);
          send_level(1'b0, len, 1'b1);
          sent += len;
        end else begin
          len = per;
          if (kind == 7)
            len = ($urandom_range(0, 1) && per > 1) ? per - 1 : per + 1;
          // kind 8 breaks the stop bit
          send_frame(rand_byte(), len, kind != 8, -1, '0, 1'b1);
          sent += 10 * len;
        end
      end
    end
  endtask

  task automatic run_phase(input logic [TICK_W-1:0] value, input int n_ticks);
    set_bit_ticks(value);
    no_gaps = ($urandom_range(0, 3) == 0);
    run_traffic(n_ticks, 1'b1);
    no_gaps = 1'b0;
  endtask

  // reset period: accept tick, start bit, requests while busy are dropped
  task automatic test_reset_period();
    send_tick(1'b1, 1'b1, 8'hFF);
    send_tick(1'b1, 1'b1, 8'h00);
    send_tick(1'b0, 1'b1, 8'h00);
    send_tick(1'b1, 1'b1, 8'h55);
  endtask

  // period 0 runs as 1: running tx frame speeds up, new request on the first idle tick after it
  task automatic test_zero_period();
    set_bit_ticks('0);
    // the rx low tick above was already taken as a start bit at period 104,
    // so these frames land in the data phase of that start bit
    send_frame(8'hFF, 1, 1'b1, -1, '0, 1'b0);
    send_frame(8'h00, 1, 1'b1, 0, 8'h00, 1'b0);
  endtask

  // largest period: tx frame stretched, rx line kept idle
  task automatic test_max_period();
    set_bit_ticks(16'hFFFF);
    run_traffic(40, 1'b0);
  endtask

  // result side stalls for a long stretch while ticks keep coming
  task automatic test_backpressure();
    no_gaps     = 1'b1;
    hold_cycles = HOLD_LEN;
    run_traffic(40, 1'b1);
    no_gaps = 1'b0;
  endtask

  task automatic test_random_traffic();
    run_phase(16'd4, 220);
    test_backpressure();
    run_phase(16'd5, 180);
    run_phase(16'd3, 150);
    run_phase(16'd2, 150);
    run_phase(16'd7, 200);
    run_phase(16'd1, 120);
    run_phase(16'd12, 240);
    run_phase(16'd6, 180);
    run_phase(16'd4, 200);
  endtask

  // result-side ready: random ready runs and stalls, plus the long hold
  initial begin : drain_ctrl
    int ready_run;
    int stall_run;
    m_tready  = 1'b0;
    ready_run = 0;
    stall_run = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_tready <= 1'b0;
      end else if (stall_run > 0) begin
        stall_run--;
        m_tready <= 1'b0;
      end else if (ready_run > 0) begin
        ready_run--;
        m_tready <= 1'b1;
      end else begin
        ready_run = $urandom_range(1, 24);
        stall_run = no_gaps ? 0 : pick_gap();
        if (stall_run > 0) begin
          stall_run--;
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
        end
      end
    end
  end

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("%0t: mismatch: %s", $time, what);
  endtask

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin : check_result
    tick_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_ticks.size() == 0) begin
        flag_mismatch($sformatf("result %h with nothing expected", m_tdata));
      end else begin
        want = expected_ticks.pop_front();
        if (m_tdata[0] !== want.tx_line)
          flag_mismatch($sformatf("tx_line exp %b got %b", want.tx_line, m_tdata[0]));
        if (m_tdata[1] !== want.tx_busy)
          flag_mismatch($sformatf("tx_busy exp %b got %b", want.tx_busy, m_tdata[1]));
        if (m_tdata[2] !== want.rx_valid)
          flag_mismatch($sformatf("rx_valid exp %b got %b", want.rx_valid, m_tdata[2]));
        if (m_tdata[10:3] !== want.rx_data)
          flag_mismatch($sformatf("rx_byte exp %h got %h", want.rx_data, m_tdata[10:3]));
        if (m_tdata[OUT_W-1:11] !== '0)
          flag_mismatch($sformatf("pad bits exp 0 got %h", m_tdata[OUT_W-1:11]));
      end
    end
  end

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    reset_prediction();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_period();
    test_zero_period();
    test_max_period();
    test_random_traffic();

    // drain, then watch for anything stray
    quiesce();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("uart_8n1_transceiver_top_test: done, clean");
    else
      $display("uart_8n1_transceiver_top_test: done, errors");
    $finish;
  end

endmodule
